// ===== rtl/core/cbm_pkg.sv =====
`default_nettype none

package cbm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BankW     = 4;
  localparam int unsigned Prg32W    = 3;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [AddrW-1:0] DecodeMask = 16'hE001;
  localparam logic [AddrW-1:0] AddrOuter  = 16'h6000;
  localparam logic [AddrW-1:0] AddrCtrl   = 16'h6001;

  localparam logic [ByteW-1:0]  DipReset     = 8'h00;
  localparam logic [BankW-1:0]  PrgMax16kRst = 4'hF;
  localparam logic [Prg32W-1:0] PrgMax32kRst = 3'h7;
  localparam logic [BankW-1:0]  ChrMax8kRst  = 4'hF;
  localparam logic [ByteW-1:0]  LockoutByte  = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    CfgDipSetting = 8'd0,
    CfgPrgMax16k  = 8'd1,
    CfgPrgMax32k  = 8'd2,
    CfgChrMax8k   = 8'd3
  } cfg_index_e;

  typedef enum logic {
    AccessRead  = 1'b0,
    AccessWrite = 1'b1
  } access_e;

  // CHR low-bit source, chr_ctrl bits 5:4
  typedef enum logic [1:0] {
    ChrInner     = 2'b00,
    ChrNone      = 2'b01,
    ChrCtrlInner = 2'b10,
    ChrCtrl      = 2'b11
  } chr_sel_e;

  typedef struct packed {
    logic [ByteW-1:0] open_bus;
    logic [ByteW-1:0] write_data;
    logic [AddrW-1:0] address;
  } in_data_t;

  typedef struct packed {
    logic [5:0]       pad;
    logic             mirror_horizontal;
    logic [BankW-1:0] chr_bank;
    logic [BankW-1:0] prg_bank;
    logic             prg_16k_mode;
    logic [ByteW-1:0] read_data;
  } out_data_t;

  function automatic logic [BankW-1:0] limit_bank(input logic [BankW-1:0] v,
                                                  input logic [BankW-1:0] max);
    return (v > max) ? (v & max) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper.sv =====
`default_nettype none

// Bank mapper for a multi-game cartridge. Each input item is one CPU bus
// access; the matching output item returns the read byte (0xFF on dipswitch
// lockout, open bus otherwise, 0 for writes) together with the PRG bank, CHR
// bank and mirroring as they stand after the access. One item per cycle:
// decode, register update and bank selection all sit between the input
// handshake and a single output register, so each result is ready in the cycle after its item is accepted, and the
// input stalls only while that output register holds an untaken item.
// The user must set bank limits and the dipswitch through the cfg port only while idle; the block does not enforce it.
module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [15:0] address, [23:16] write_data, [31:24] open_bus
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // [0] mode
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] read_data, [8] prg_16k_mode, [12:9] prg_bank, [16:13] chr_bank,
  // [17] mirror_horizontal, [23:18] zero
  output logic [OutDataW-1:0]       m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]     cfg_data_i
);

  logic [ByteW-1:0]  dip_q;
  logic [BankW-1:0]  prg_max_16k_q;
  logic [Prg32W-1:0] prg_max_32k_q;
  logic [BankW-1:0]  chr_max_8k_q;

  logic [ByteW-1:0] outer_q, outer_d;
  logic [ByteW-1:0] ctrl_q, ctrl_d;
  logic [ByteW-1:0] inner_q, inner_d;

  logic      out_valid_q;
  out_data_t out_q, out_d;

  in_data_t         in_item;
  logic             in_fire;
  logic [AddrW-1:0] dec;
  logic [BankW-1:0] prg_raw;
  logic [BankW-1:0] chr_raw;
  logic [1:0]       chr_low;

  assign in_item       = in_data_t'(s_axis_tdata);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q         <= DipReset;
      prg_max_16k_q <= PrgMax16kRst;
      prg_max_32k_q <= PrgMax32kRst;
      chr_max_8k_q  <= ChrMax8kRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgDipSetting: dip_q         <= cfg_data_i;
        CfgPrgMax16k:  prg_max_16k_q <= cfg_data_i[BankW-1:0];
        CfgPrgMax32k:  prg_max_32k_q <= cfg_data_i[Prg32W-1:0];
        CfgChrMax8k:   chr_max_8k_q  <= cfg_data_i[BankW-1:0];
        default: ;
      endcase
    end
  end

  // Register writes
  always_comb begin
    dec     = in_item.address & DecodeMask;
    outer_d = outer_q;
    ctrl_d  = ctrl_q;
    inner_d = inner_q;
    if (access_e'(s_axis_tuser) == AccessWrite) begin
      if (dec == AddrOuter) begin
        outer_d = in_item.write_data;
      end else if (dec == AddrCtrl) begin
        ctrl_d = in_item.write_data;
      end else if (in_item.address[AddrW-1]) begin
        inner_d = in_item.write_data;
      end
    end
  end

  // Result from the updated registers
  always_comb begin
    case (chr_sel_e'(ctrl_d[5:4]))
      ChrInner:     chr_low = inner_d[1:0];
      ChrNone:      chr_low = 2'b00;
      ChrCtrlInner: chr_low = {ctrl_d[1], inner_d[0]};
      ChrCtrl:      chr_low = ctrl_d[1:0];
      default:      chr_low = 2'b00;
    endcase
    chr_raw = {outer_d[6], ctrl_d[2], chr_low};

    if (outer_d[3]) begin
      prg_raw = limit_bank({outer_d[6], outer_d[2:0]}, prg_max_16k_q);
    end else begin
      prg_raw = limit_bank({1'b0, outer_d[6], outer_d[2:1]}, {1'b0, prg_max_32k_q});
    end

    out_d                   = '0;
    out_d.prg_16k_mode      = outer_d[3];
    out_d.prg_bank          = prg_raw;
    out_d.chr_bank          = limit_bank(chr_raw, chr_max_8k_q);
    out_d.mirror_horizontal = outer_d[4];
    if (access_e'(s_axis_tuser) == AccessRead) begin
      if (in_item.address[AddrW-1] && ((ctrl_q[7:6] & dip_q[7:6]) != 2'b00)) begin
        out_d.read_data = LockoutByte;
      end else begin
        out_d.read_data = in_item.open_bus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q     <= '0;
      ctrl_q      <= '0;
      inner_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        outer_q     <= outer_d;
        ctrl_q      <= ctrl_d;
        inner_q     <= inner_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbm_checker.sv =====
`default_nettype none

module cbm_checker
  import cbm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutDataW-1:0]  m_axis_tdata
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Every accepted item shows up at the output in the next cycle
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted item did not reach the output");

  // A stalled result blocks the input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // Writes return zero read data
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (access_e'(s_axis_tuser) == AccessWrite) |=> m_axis_tdata[ByteW-1:0] == '0)
    else $error("write item returned nonzero read data");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped before taken");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled output item changed");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam int unsigned Watchdog = 200000;
  localparam int unsigned Phases = 8;
  localparam int unsigned PhaseItems = 150;
  localparam logic [CfgIndexW-1:0] CfgUnusedBase = 8'd4;

  typedef enum logic {
    RowAccess,
    RowSetting
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    access_e              acc;
    logic [AddrW-1:0]     addr;
    logic [ByteW-1:0]     wdata;
    logic [ByteW-1:0]     obus;
    logic [CfgIndexW-1:0] reg_idx;
    logic [ByteW-1:0]     reg_val;
    bit                   pinned;
    out_data_t            result;
  } bus_step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tuser = AccessRead;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]     cfg_data_i = '0;

  // expectation tag travelling alongside the input item
  bit        pin_use = 1'b0;
  out_data_t pin_result = '0;

  // predictor state
  logic [ByteW-1:0]  bank_outer = '0;
  logic [ByteW-1:0]  bank_chr_ctrl = '0;
  logic [ByteW-1:0]  bank_inner = '0;
  logic [ByteW-1:0]  lim_dip = DipReset;
  logic [BankW-1:0]  lim_prg16 = PrgMax16kRst;
  logic [Prg32W-1:0] lim_prg32 = PrgMax32kRst;
  logic [BankW-1:0]  lim_chr = ChrMax8kRst;

  out_data_t   mapped_results[$];
  bus_step_t   plan[$];
  int unsigned feed_idle_pct = 0;
  int unsigned drain_stall_pct = 0;
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_lockout = 0;
  int unsigned n_reg_writes = 0;
  int unsigned cycles = 0;

  cartridge_bank_mapper DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [BankW-1:0] clamp_bank(logic [BankW-1:0] idx, logic [BankW-1:0] top);
    return (idx > top) ? (idx & top) : idx;
  endfunction

  // Update the register copies for one bus access and return the mapper's view after it.
  function automatic out_data_t map_access(access_e kind, in_data_t bus);
    out_data_t        res;
    logic [AddrW-1:0] dec;
    logic [1:0]       low2;
    res = '0;
    dec = bus.address & DecodeMask;
    if (kind == AccessWrite) begin
      if (dec == AddrOuter) begin
        bank_outer = bus.write_data;
      end else if (dec == AddrCtrl) begin
        bank_chr_ctrl = bus.write_data;
      end else if (bus.address[15]) begin
        bank_inner = bus.write_data;
      end
    end else begin
      res.read_data = bus.open_bus;
      if (bus.address[15] && |(bank_chr_ctrl[7:6] & lim_dip[7:6])) begin
        res.read_data = LockoutByte;
        n_lockout++;
      end
    end
    res.prg_16k_mode = bank_outer[3];
    if (bank_outer[3]) begin
      res.prg_bank = clamp_bank({bank_outer[6], bank_outer[2:0]}, lim_prg16);
    end else begin
      res.prg_bank = clamp_bank({1'b0, bank_outer[6], bank_outer[2:1]}, {1'b0, lim_prg32});
    end
    case (chr_sel_e'(bank_chr_ctrl[5:4]))
      ChrInner:     low2 = bank_inner[1:0];
      ChrCtrlInner: low2 = {bank_chr_ctrl[1], bank_inner[0]};
      ChrCtrl:      low2 = bank_chr_ctrl[1:0];
      default:      low2 = 2'b00;
    endcase
    res.chr_bank = clamp_bank({bank_outer[6], bank_chr_ctrl[2], low2}, lim_chr);
    res.mirror_horizontal = bank_outer[4];
    return res;
  endfunction

  function automatic bus_step_t acc_row(access_e kind, logic [AddrW-1:0] addr,
                                        logic [ByteW-1:0] wd, logic [ByteW-1:0] ob);
    bus_step_t row;
    row = '{kind: RowAccess, acc: kind, addr: addr, wdata: wd, obus: ob,
            reg_idx: '0, reg_val: '0, pinned: 1'b0, result: '0};
    return row;
  endfunction

  // Access whose banks are all zero: only the returned byte needs stating.
  function automatic bus_step_t held_row(access_e kind, logic [AddrW-1:0] addr,
                                         logic [ByteW-1:0] wd, logic [ByteW-1:0] ob,
                                         logic [ByteW-1:0] rd);
    bus_step_t row;
    row = acc_row(kind, addr, wd, ob);
    row.pinned = 1'b1;
    row.result.read_data = rd;
    return row;
  endfunction

  function automatic bus_step_t set_row(logic [CfgIndexW-1:0] idx, logic [ByteW-1:0] val);
    bus_step_t row;
    row = acc_row(AccessRead, '0, '0, '0);
    row.kind = RowSetting;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic push_access(bus_step_t row);
    while ($urandom_range(99) < feed_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.obus, row.wdata, row.addr};
    s_axis_tuser  <= row.acc;
    pin_use       <= row.pinned;
    pin_result    <= row.result;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold cfg_valid_i high; the caller drops it after the last write of a batch.
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Let the monitor record the last accepted item before checking for drain.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mapped_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= drain_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Watchdog) begin
      $display("cartridge_bank_mapper: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_data_t want;
    out_data_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        n_reg_writes++;
        case (cfg_index_i)
          CfgDipSetting: lim_dip = cfg_data_i;
          CfgPrgMax16k:  lim_prg16 = cfg_data_i[BankW-1:0];
          CfgPrgMax32k:  lim_prg32 = cfg_data_i[Prg32W-1:0];
          CfgChrMax8k:   lim_chr = cfg_data_i[BankW-1:0];
          default: ;
        endcase
      end
      // pop before push so an item with no expectation waiting is caught
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_data_t'(m_axis_tdata);
        if (mapped_results.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          n_fail++;
        end else begin
          want = mapped_results.pop_front();
          n_checked++;
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            n_fail++;
          end
          if (got.prg_16k_mode !== want.prg_16k_mode) begin
            $error("prg_16k_mode: expected %b, got %b", want.prg_16k_mode, got.prg_16k_mode);
            n_fail++;
          end
          if (got.prg_bank !== want.prg_bank) begin
            $error("prg_bank: expected %0d, got %0d", want.prg_bank, got.prg_bank);
            n_fail++;
          end
          if (got.chr_bank !== want.chr_bank) begin
            $error("chr_bank: expected %0d, got %0d", want.chr_bank, got.chr_bank);
            n_fail++;
          end
          if (got.mirror_horizontal !== want.mirror_horizontal) begin
            $error("mirror_horizontal: expected %b, got %b", want.mirror_horizontal,
                   got.mirror_horizontal);
            n_fail++;
          end
          if (got.pad !== want.pad) begin
            $error("pad: expected %h, got %h", want.pad, got.pad);
            n_fail++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = map_access(access_e'(s_axis_tuser), in_data_t'(s_axis_tdata));
        if (pin_use) want = pin_result;
        mapped_results.push_back(want);
      end
    end
  end

  initial begin
    bus_step_t        row;
    int unsigned      sel;
    logic [AddrW-1:0] raw;

    // reset state, writes that miss every register, then the dipswitch lockout
    plan.push_back(held_row(AccessRead,  16'h0000, 8'h00, 8'h00, 8'h00));
    plan.push_back(held_row(AccessRead,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    plan.push_back(held_row(AccessRead,  16'h7FFF, 8'h00, 8'hA5, 8'hA5));
    plan.push_back(held_row(AccessWrite, 16'h5FFF, 8'hFF, 8'hFF, 8'h00));
    plan.push_back(held_row(AccessWrite, 16'h2001, 8'hFF, 8'h5A, 8'h00));
    plan.push_back(set_row(CfgDipSetting, 8'h40));
    plan.push_back(held_row(AccessWrite, 16'h6001, 8'hC0, 8'h00, 8'h00));
    plan.push_back(held_row(AccessRead,  16'h8000, 8'h00, 8'h12, LockoutByte));
    plan.push_back(held_row(AccessRead,  16'h7FFF, 8'h00, 8'h34, 8'h34));
    plan.push_back(set_row(CfgDipSetting, 8'h80));
    plan.push_back(held_row(AccessRead,  16'hC000, 8'h00, 8'h56, LockoutByte));
    plan.push_back(set_row(CfgDipSetting, 8'h3F));
    plan.push_back(held_row(AccessRead,  16'hFFFF, 8'h00, 8'h00, 8'h00));
    // register decode aliases and every CHR low-bit source
    plan.push_back(acc_row(AccessWrite, 16'h6000, 8'hFF, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'h8000, 8'h03, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'hE001, 8'hFE, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'h7001, 8'h10, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'h6003, 8'h22, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'h6001, 8'h37, 8'h00));
    plan.push_back(acc_row(AccessWrite, 16'h7FFE, 8'h08, 8'h00));
    // zero maxima force every bank to zero
    plan.push_back(set_row(CfgPrgMax16k, 8'h00));
    plan.push_back(set_row(CfgPrgMax32k, 8'h00));
    plan.push_back(set_row(CfgChrMax8k, 8'h00));
    plan.push_back(acc_row(AccessRead,  16'h1234, 8'h00, 8'h77));
    plan.push_back(acc_row(AccessWrite, 16'h6000, 8'h4E, 8'h00));
    // oversized values are truncated; an unused index changes nothing
    plan.push_back(set_row(CfgPrgMax16k, 8'hFF));
    plan.push_back(set_row(CfgPrgMax32k, 8'hFF));
    plan.push_back(set_row(CfgChrMax8k, 8'hFF));
    plan.push_back(set_row(CfgUnusedBase, 8'hFF));
    plan.push_back(set_row(CfgDipSetting, 8'h00));
    plan.push_back(acc_row(AccessRead,  16'h8000, 8'h00, 8'hC3));
    plan.push_back(acc_row(AccessWrite, 16'h6000, 8'h0F, 8'h00));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < plan.size(); r++) begin
      if (plan[r].kind == RowSetting) begin
        if (r == 0 || plan[r-1].kind != RowSetting) settle_idle();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
        if (r + 1 == plan.size() || plan[r+1].kind != RowSetting) cfg_valid_i <= 1'b0;
      end else begin
        push_access(plan[r]);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle_idle();
      case (ph)
        0: begin
          write_reg(CfgDipSetting, 8'h00);
          write_reg(CfgPrgMax16k, 8'h0F);
          write_reg(CfgPrgMax32k, 8'h07);
          write_reg(CfgChrMax8k, 8'h0F);
        end
        1: begin
          write_reg(CfgDipSetting, 8'h40);
          write_reg(CfgPrgMax16k, 8'h00);
          write_reg(CfgPrgMax32k, 8'h00);
          write_reg(CfgChrMax8k, 8'h00);
        end
        2: begin
          write_reg(CfgDipSetting, 8'h80);
          write_reg(CfgPrgMax16k, 8'hF0);
          write_reg(CfgPrgMax32k, 8'hF8);
          write_reg(CfgChrMax8k, 8'hF0);
        end
        3: begin
          write_reg(CfgDipSetting, 8'hC0);
          write_reg(CfgPrgMax16k, 8'h07);
          write_reg(CfgPrgMax32k, 8'h03);
          write_reg(CfgChrMax8k, 8'h05);
        end
        default: begin
          write_reg(CfgDipSetting, 8'($urandom_range(255)));
          write_reg(CfgPrgMax16k, 8'($urandom_range(255)));
          write_reg(CfgPrgMax32k, 8'($urandom_range(255)));
          write_reg(CfgChrMax8k, 8'($urandom_range(255)));
        end
      endcase
      write_reg(8'($urandom_range(255, CfgUnusedBase)), 8'($urandom_range(255)));
      cfg_valid_i <= 1'b0;

      case (ph % 4)
        0: begin feed_idle_pct = 0;  drain_stall_pct = 0;  end
        1: begin feed_idle_pct = 60; drain_stall_pct = 0;  end
        2: begin feed_idle_pct = 0;  drain_stall_pct = 60; end
        default: begin feed_idle_pct = 23; drain_stall_pct = 23; end
      endcase

      repeat (PhaseItems) begin
        raw = 16'($urandom());
        sel = $urandom_range(9);
        // mostly register and cartridge-space addresses, some arbitrary addresses
        if (sel < 3) begin
          raw = (raw & ~DecodeMask) | AddrOuter;
        end else if (sel < 5) begin
          raw = (raw & ~DecodeMask) | AddrCtrl;
        end else if (sel < 8) begin
          raw[15] = 1'b1;
        end
        row = acc_row($urandom_range(1) ? AccessWrite : AccessRead, raw,
                      8'($urandom()), 8'($urandom()));
        push_access(row);
      end
    end

    settle_idle();
    repeat (10) @(posedge clk_i);
    $display("checked %0d bus accesses under %0d register settings and idle/stall mixes",
             n_checked, Phases + 1);
    $display("%0d reads hit the dipswitch lockout; %0d register writes taken",
             n_lockout, n_reg_writes);
    if (n_fail == 0) begin
      $display("cartridge_bank_mapper: match");
    end else begin
      $display("cartridge_bank_mapper: mismatch");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_mapper.f =====
rtl/core/cbm_pkg.sv
rtl/core/cartridge_bank_mapper.sv
rtl/core/cbm_checker.sv
bench/testbench.sv
